// ----- rtl/usrd_pkg.sv -----
// Package for the USB standard request decoder: transaction structs, request and
// descriptor codes, reply kinds and configuration register indexes.
// No dependencies.
package usrd_pkg;

    localparam int STRING_COUNT      = 4;
    localparam int MAX_CONFIGURATION = 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_SPEED        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_DESC_LEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUALIFIER_DESC_LEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HS_CONFIG_LEN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FS_CONFIG_LEN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LENGTHS    = 3'd5;

    localparam logic [7:0] DEVICE_DESC_LEN_RESET    = 8'd18;
    localparam logic [7:0] QUALIFIER_DESC_LEN_RESET = 8'd10;

    localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

    localparam logic [7:0] DT_DEVICE      = 8'd1;
    localparam logic [7:0] DT_CONFIG      = 8'd2;
    localparam logic [7:0] DT_STRING      = 8'd3;
    localparam logic [7:0] DT_QUALIFIER   = 8'd6;
    localparam logic [7:0] DT_OTHER_SPEED = 8'd7;

    localparam logic [1:0] TYPE_STANDARD    = 2'd0;
    localparam logic [4:0] RECIP_DEVICE     = 5'd0;
    localparam logic [4:0] RECIP_INTERFACE  = 5'd1;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_DEVICE    = 3'd1;
    localparam logic [2:0] KIND_QUALIFIER = 3'd2;
    localparam logic [2:0] KIND_CONFIG    = 3'd3;
    localparam logic [2:0] KIND_OTHER     = 3'd4;
    localparam logic [2:0] KIND_STRING    = 3'd5;
    localparam logic [2:0] KIND_BYTE      = 3'd6;

    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } request_t;

    typedef struct packed {
        logic        stall_res;
        logic [2:0]  reply_kind;
        logic        reply_from_high_set;
        logic [1:0]  string_number;
        logic [15:0] reply_length;
        logic [7:0]  reply_byte;
        logic        endpoint_reconfigure;
        logic        endpoint_enable;
        logic        endpoint_high_speed;
    } result_t;

    typedef struct packed {
        logic        high_speed;
        logic [7:0]  device_desc_length;
        logic [7:0]  qualifier_desc_length;
        logic [15:0] hs_config_total_length;
        logic [15:0] fs_config_total_length;
        logic [31:0] string_lengths;
    } cfg_t;

    typedef struct packed {
        logic       write;
        logic [7:0] value;
    } config_update_t;

endpackage

// ----- rtl/usb_standard_request_decoder_unit.sv -----
// USB standard request decoder, top level: request register, decode, result register.
// An accepted request transaction is held in the request register, decoded and then
// registered in the result register. Throughput: one transaction per cycle while the
// consumer takes results; the result register decouples a stalled consumer. Reset clears
// both valid flags and the current configuration and loads the configuration registers
// with their reset values. Depends on usrd_pkg, usrd_cfg_regs and usrd_decode.
module usb_standard_request_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  usrd_pkg::request_t                req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output usrd_pkg::result_t                 rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [usrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [usrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import usrd_pkg::*;

    cfg_t           cfg;
    request_t       req_reg;
    logic           req_valid_reg;
    logic           req_valid_next;
    result_t        rsp_reg;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    result_t        dec_rsp;
    config_update_t dec_upd;
    logic [7:0]     cur_config_reg;
    logic           advance;
    logic           accept;

    assign cfg_ready = 1'b1;

    usrd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    usrd_decode u_decode (
        .req                   (req_reg),
        .cfg                   (cfg),
        .current_configuration (cur_config_reg),
        .rsp                   (dec_rsp),
        .upd                   (dec_upd)
    );

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    assign req_valid_next = accept || (req_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            cur_config_reg <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance && dec_upd.write)
            begin
                cur_config_reg <= dec_upd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= dec_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_stall_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.stall_res) |->
            (rsp_reg.reply_kind == KIND_NONE && rsp_reg.reply_length == 16'd0 &&
             !rsp_reg.endpoint_reconfigure))
        else $error("Stalled result carries reply fields.");

    a_ep_hs_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.endpoint_high_speed) |-> rsp_reg.endpoint_enable)
        else $error("Endpoint high speed set without endpoint enable.");

    a_config_update: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && dec_upd.write) |=> (cur_config_reg == $past(req_reg.request_value[7:0])))
        else $error("Current configuration not updated by set configuration.");

    a_config_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_config_reg <= 8'(MAX_CONFIGURATION))
        else $error("Current configuration above the supported maximum.");

    a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(req_reg)))
        else $error("Pending request lost while the result register was full.");

endmodule

// ----- rtl/usrd_cfg_regs.sv -----
// Configuration register file of the USB standard request decoder.
// Depends on usrd_pkg.
module usrd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [usrd_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [usrd_pkg::CFG_DATA_W-1:0]   wr_data,
    output usrd_pkg::cfg_t                    cfg
);
    import usrd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_speed             <= 1'b0;
            cfg_reg.device_desc_length     <= DEVICE_DESC_LEN_RESET;
            cfg_reg.qualifier_desc_length  <= QUALIFIER_DESC_LEN_RESET;
            cfg_reg.hs_config_total_length <= '0;
            cfg_reg.fs_config_total_length <= '0;
            cfg_reg.string_lengths         <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_HIGH_SPEED:         cfg_reg.high_speed             <= wr_data[0];
                CFG_DEVICE_DESC_LEN:    cfg_reg.device_desc_length     <= wr_data[7:0];
                CFG_QUALIFIER_DESC_LEN: cfg_reg.qualifier_desc_length  <= wr_data[7:0];
                CFG_HS_CONFIG_LEN:      cfg_reg.hs_config_total_length <= wr_data[15:0];
                CFG_FS_CONFIG_LEN:      cfg_reg.fs_config_total_length <= wr_data[15:0];
                CFG_STRING_LENGTHS:     cfg_reg.string_lengths         <= wr_data[31:0];
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/usrd_decode.sv -----
// Combinational decode of one setup request into its control reply and the
// configuration update it causes. Depends on usrd_pkg.
module usrd_decode (
    input  usrd_pkg::request_t        req,
    input  usrd_pkg::cfg_t            cfg,
    input  logic [7:0]                current_configuration,
    output usrd_pkg::result_t         rsp,
    output usrd_pkg::config_update_t  upd
);
    import usrd_pkg::*;

    logic [4:0]  recip;
    logic [7:0]  dtype;
    logic [7:0]  low_value;
    logic [15:0] desc_len;
    logic        ok;
    result_t     res;
    config_update_t upd_raw;

    assign recip     = req.request_type[4:0];
    assign dtype     = req.request_value[15:8];
    assign low_value = req.request_value[7:0];

    always_comb
    begin
        res      = '0;
        upd_raw  = '0;
        ok       = 1'b0;
        desc_len = '0;
        if (req.request_type[6:5] == TYPE_STANDARD)
        begin
            unique case (req.request_code)
                RQ_GET_DESCRIPTOR:
                begin
                    if (recip == RECIP_DEVICE)
                    begin
                        ok = 1'b1;
                        unique case (dtype)
                            DT_DEVICE:
                            begin
                                res.reply_kind          = KIND_DEVICE;
                                res.reply_from_high_set = cfg.high_speed;
                                desc_len = {8'd0, cfg.device_desc_length};
                            end
                            DT_QUALIFIER:
                            begin
                                res.reply_kind          = KIND_QUALIFIER;
                                res.reply_from_high_set = cfg.high_speed;
                                desc_len = {8'd0, cfg.qualifier_desc_length};
                            end
                            DT_CONFIG:
                            begin
                                res.reply_kind          = KIND_CONFIG;
                                res.reply_from_high_set = cfg.high_speed;
                                desc_len = cfg.high_speed ? cfg.hs_config_total_length
                                                          : cfg.fs_config_total_length;
                            end
                            DT_OTHER_SPEED:
                            begin
                                res.reply_kind          = KIND_OTHER;
                                res.reply_from_high_set = !cfg.high_speed;
                                desc_len = cfg.high_speed ? cfg.fs_config_total_length
                                                          : cfg.hs_config_total_length;
                            end
                            DT_STRING:
                            begin
                                if (low_value < 8'(STRING_COUNT))
                                begin
                                    res.reply_kind    = KIND_STRING;
                                    res.string_number = low_value[1:0];
                                    desc_len = {8'd0,
                                        cfg.string_lengths[{low_value[1:0], 3'b000} +: 8]};
                                end
                                else
                                begin
                                    ok = 1'b0;
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                        res.reply_length = (req.request_length < desc_len)
                                         ? req.request_length : desc_len;
                    end
                end
                RQ_GET_CONFIGURATION:
                begin
                    if (recip == RECIP_DEVICE)
                    begin
                        ok               = 1'b1;
                        res.reply_kind   = KIND_BYTE;
                        res.reply_length = 16'd1;
                        res.reply_byte   = current_configuration;
                    end
                end
                RQ_SET_CONFIGURATION:
                begin
                    if (recip == RECIP_DEVICE &&
                        req.request_value <= 16'(MAX_CONFIGURATION))
                    begin
                        ok                       = 1'b1;
                        upd_raw.write            = 1'b1;
                        upd_raw.value            = low_value;
                        res.endpoint_reconfigure = 1'b1;
                        res.endpoint_enable      = (low_value != 8'd0);
                        res.endpoint_high_speed  = (low_value != 8'd0) && cfg.high_speed;
                    end
                end
                RQ_GET_INTERFACE:
                begin
                    if (recip == RECIP_INTERFACE)
                    begin
                        ok               = 1'b1;
                        res.reply_kind   = KIND_BYTE;
                        res.reply_length = 16'd1;
                    end
                end
                RQ_SET_INTERFACE:
                begin
                    ok = (recip == RECIP_INTERFACE) &&
                         (req.request_index[7:0] == 8'd0) && (low_value == 8'd0);
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok)
        begin
            res           = '0;
            res.stall_res = 1'b1;
            upd_raw       = '0;
        end
    end

    assign rsp = res;
    assign upd = upd_raw;

endmodule

// ----- tb/sv/usb_standard_request_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for usb_standard_request_decoder_unit: a directed table, then
// random setup requests under several register settings; each reply is scored against
// a pinned reply or a predictor. Depends on usrd_pkg and the decoder RTL.
module usb_standard_request_decoder_unit_tb;

    import usrd_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTING_COUNT = 6;
    localparam int ITEMS_PER_SETTING = 292;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [7:0] RQ_GET_STATUS = 8'd0;
    localparam logic [7:0] RQ_UNDEFINED = 8'hFF;
    localparam logic [7:0] DT_INTERFACE = 8'd4;
    localparam logic [7:0] DT_UNDEFINED = 8'hFF;

    localparam logic [7:0] DESC_TYPES [0:4] =
        '{DT_DEVICE, DT_CONFIG, DT_STRING, DT_QUALIFIER, DT_OTHER_SPEED};
    localparam logic [7:0] REQUEST_CODES [0:4] = '{RQ_GET_DESCRIPTOR, RQ_GET_CONFIGURATION,
        RQ_SET_CONFIGURATION, RQ_GET_INTERFACE, RQ_SET_INTERFACE};

    localparam result_t STALL_REPLY = {1'b1, {($bits(result_t) - 1){1'b0}}};

    typedef struct packed {
        logic    pinned;
        result_t reply;
    } pinned_reply_t;

    typedef struct packed {
        request_t      req;
        pinned_reply_t outcome;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    request_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    result_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfg_t link_regs = '{1'b0, DEVICE_DESC_LEN_RESET, QUALIFIER_DESC_LEN_RESET,
                        16'd0, 16'd0, 32'd0};
    logic [7:0] configuration_value = 8'd0;

    result_t reply_q [$];
    pinned_reply_t pinned_q [$];
    stim_row_t directed_rows [$];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int errors = 0;
    int cycle_count = 0;

    usb_standard_request_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic result_t decode_request(input request_t q);
        result_t res;
        logic ok;
        logic [4:0] recip;
        logic [15:0] desc_len;
        logic [1:0] str_idx;
        res = '0;
        ok = 1'b0;
        desc_len = '0;
        recip = q.request_type[4:0];
        str_idx = q.request_value[1:0];
        if (q.request_type[6:5] == TYPE_STANDARD)
        begin
            case (q.request_code)
                RQ_GET_DESCRIPTOR:
                    if (recip == RECIP_DEVICE)
                    begin
                        ok = 1'b1;
                        case (q.request_value[15:8])
                            DT_DEVICE:
                            begin
                                res.reply_kind = KIND_DEVICE;
                                res.reply_from_high_set = link_regs.high_speed;
                                desc_len = {8'd0, link_regs.device_desc_length};
                            end
                            DT_QUALIFIER:
                            begin
                                res.reply_kind = KIND_QUALIFIER;
                                res.reply_from_high_set = link_regs.high_speed;
                                desc_len = {8'd0, link_regs.qualifier_desc_length};
                            end
                            DT_CONFIG:
                            begin
                                res.reply_kind = KIND_CONFIG;
                                res.reply_from_high_set = link_regs.high_speed;
                                desc_len = link_regs.high_speed ?
                                    link_regs.hs_config_total_length :
                                    link_regs.fs_config_total_length;
                            end
                            DT_OTHER_SPEED:
                            begin
                                res.reply_kind = KIND_OTHER;
                                res.reply_from_high_set = ~link_regs.high_speed;
                                desc_len = link_regs.high_speed ?
                                    link_regs.fs_config_total_length :
                                    link_regs.hs_config_total_length;
                            end
                            DT_STRING:
                                if (q.request_value[7:0] < 8'(STRING_COUNT))
                                begin
                                    res.reply_kind = KIND_STRING;
                                    res.string_number = str_idx;
                                    desc_len = {8'd0,
                                        link_regs.string_lengths[{str_idx, 3'b000} +: 8]};
                                end
                                else
                                begin
                                    ok = 1'b0;
                                end
                            default:
                                ok = 1'b0;
                        endcase
                        res.reply_length = (q.request_length < desc_len) ?
                            q.request_length : desc_len;
                    end
                RQ_GET_CONFIGURATION:
                    if (recip == RECIP_DEVICE)
                    begin
                        ok = 1'b1;
                        res.reply_kind = KIND_BYTE;
                        res.reply_length = 16'd1;
                        res.reply_byte = configuration_value;
                    end
                RQ_SET_CONFIGURATION:
                    if (recip == RECIP_DEVICE && q.request_value <= 16'(MAX_CONFIGURATION))
                    begin
                        ok = 1'b1;
                        configuration_value = q.request_value[7:0];
                        res.endpoint_reconfigure = 1'b1;
                        res.endpoint_enable = (configuration_value != 8'd0);
                        res.endpoint_high_speed = res.endpoint_enable & link_regs.high_speed;
                    end
                RQ_GET_INTERFACE:
                    if (recip == RECIP_INTERFACE)
                    begin
                        ok = 1'b1;
                        res.reply_kind = KIND_BYTE;
                        res.reply_length = 16'd1;
                    end
                RQ_SET_INTERFACE:
                    ok = (recip == RECIP_INTERFACE) && (q.request_index[7:0] == 8'd0) &&
                         (q.request_value[7:0] == 8'd0);
                default:
                    ok = 1'b0;
            endcase
        end
        if (!ok)
        begin
            res = STALL_REPLY;
        end
        return res;
    endfunction

    function automatic result_t reply_of(input logic stall, input logic [2:0] kind,
                                         input logic high, input logic [1:0] num,
                                         input logic [15:0] len, input logic [7:0] value,
                                         input logic reconf, input logic en, input logic ehs);
        return '{stall, kind, high, num, len, value, reconf, en, ehs};
    endfunction

    function automatic logic [15:0] random_length();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 32));
            1: return 16'($urandom_range(0, 300));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic request_t random_request();
        request_t q;
        int pick;
        pick = $urandom_range(0, 99);
        q.request_type = {1'($urandom_range(0, 1)), TYPE_STANDARD, RECIP_DEVICE};
        q.request_value = 16'($urandom);
        q.request_index = 16'($urandom);
        q.request_length = random_length();
        if (pick < 40)
        begin
            q.request_code = RQ_GET_DESCRIPTOR;
            q.request_value[15:8] = DESC_TYPES[$urandom_range(0, 4)];
            if ($urandom_range(0, 3) != 0)
            begin
                q.request_value[7:0] = 8'($urandom_range(0, STRING_COUNT - 1));
            end
        end
        else if (pick < 50)
        begin
            q.request_code = RQ_GET_CONFIGURATION;
        end
        else if (pick < 62)
        begin
            q.request_code = RQ_SET_CONFIGURATION;
            if ($urandom_range(0, 3) != 0)
            begin
                q.request_value = 16'($urandom_range(0, MAX_CONFIGURATION));
            end
        end
        else if (pick < 70)
        begin
            q.request_type[4:0] = RECIP_INTERFACE;
            q.request_code = RQ_GET_INTERFACE;
        end
        else if (pick < 80)
        begin
            q.request_type[4:0] = RECIP_INTERFACE;
            q.request_code = RQ_SET_INTERFACE;
            if ($urandom_range(0, 2) != 0)
            begin
                q.request_value[7:0] = 8'd0;
                q.request_index[7:0] = 8'd0;
            end
        end
        else if (pick < 90)
        begin
            q.request_type = 8'($urandom);
            q.request_code = REQUEST_CODES[$urandom_range(0, 4)];
        end
        else
        begin
            q.request_type = 8'($urandom);
            q.request_code = 8'($urandom);
        end
        return q;
    endfunction

    task automatic add_row(input logic [7:0] rtype, input logic [7:0] code,
                           input logic [15:0] value, input logic [15:0] index,
                           input logic [15:0] len, input logic pinned, input result_t reply);
        stim_row_t row;
        row.req = '{rtype, code, value, index, len};
        row.outcome = '{pinned, reply};
        directed_rows.push_back(row);
    endtask

    task automatic send_req(input request_t r, input pinned_reply_t outcome);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            gap++;
        end
        pinned_q.push_back(outcome);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_HIGH_SPEED:         link_regs.high_speed = data[0];
            CFG_DEVICE_DESC_LEN:    link_regs.device_desc_length = data[7:0];
            CFG_QUALIFIER_DESC_LEN: link_regs.qualifier_desc_length = data[7:0];
            CFG_HS_CONFIG_LEN:      link_regs.hs_config_total_length = data[15:0];
            CFG_FS_CONFIG_LEN:      link_regs.fs_config_total_length = data[15:0];
            CFG_STRING_LENGTHS:     link_regs.string_lengths = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_setting(input int setting);
        case (setting)
            0:
            begin
                write_reg(CFG_HIGH_SPEED, 32'd1);
                write_reg(CFG_DEVICE_DESC_LEN, 32'hFF);
                write_reg(CFG_QUALIFIER_DESC_LEN, 32'hFF);
                write_reg(CFG_HS_CONFIG_LEN, 32'hFFFF);
                write_reg(CFG_FS_CONFIG_LEN, 32'hFFFF);
                write_reg(CFG_STRING_LENGTHS, 32'hFFFF_FFFF);
            end
            1:
            begin
                write_reg(CFG_HIGH_SPEED, 32'd0);
                write_reg(CFG_DEVICE_DESC_LEN, 32'd0);
                write_reg(CFG_QUALIFIER_DESC_LEN, 32'd0);
                write_reg(CFG_HS_CONFIG_LEN, 32'd0);
                write_reg(CFG_FS_CONFIG_LEN, 32'd0);
                write_reg(CFG_STRING_LENGTHS, 32'd0);
            end
            default:
            begin
                write_reg(CFG_HIGH_SPEED, {31'($urandom), 1'(setting)});
                write_reg(CFG_DEVICE_DESC_LEN, $urandom);
                write_reg(CFG_QUALIFIER_DESC_LEN, $urandom);
                write_reg(CFG_HS_CONFIG_LEN, $urandom_range(0, 600) | ($urandom & 32'hFFFF_0000));
                write_reg(CFG_FS_CONFIG_LEN, $urandom);
                write_reg(CFG_STRING_LENGTHS, $urandom);
            end
        endcase
        write_reg(CFG_UNUSED, $urandom);
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        pinned_reply_t outcome;
        result_t predicted;
        if (rst_n && req_valid && req_ready)
        begin
            outcome = pinned_q.pop_front();
            predicted = decode_request(req);
            reply_q.push_back(outcome.pinned ? outcome.reply : predicted);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected result transaction 0x%0h", $time, rsp);
                errors++;
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("stall_res", 32'(want.stall_res), 32'(rsp.stall_res));
                check_field("reply_kind", 32'(want.reply_kind), 32'(rsp.reply_kind));
                check_field("reply_from_high_set", 32'(want.reply_from_high_set),
                            32'(rsp.reply_from_high_set));
                check_field("string_number", 32'(want.string_number),
                            32'(rsp.string_number));
                check_field("reply_length", 32'(want.reply_length), 32'(rsp.reply_length));
                check_field("reply_byte", 32'(want.reply_byte), 32'(rsp.reply_byte));
                check_field("endpoint_reconfigure", 32'(want.endpoint_reconfigure),
                            32'(rsp.endpoint_reconfigure));
                check_field("endpoint_enable", 32'(want.endpoint_enable),
                            32'(rsp.endpoint_enable));
                check_field("endpoint_high_speed", 32'(want.endpoint_high_speed),
                            32'(rsp.endpoint_high_speed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                reply_of(1'b0, KIND_DEVICE, 1'b0, 2'd0, {8'd0, DEVICE_DESC_LEN_RESET},
                         8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h00, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000, 16'd8, 1'b1,
                reply_of(1'b0, KIND_DEVICE, 1'b0, 2'd0, 16'd8, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_QUALIFIER, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                reply_of(1'b0, KIND_QUALIFIER, 1'b0, 2'd0, {8'd0, QUALIFIER_DESC_LEN_RESET},
                         8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'h0040, 1'b1,
                reply_of(1'b0, KIND_CONFIG, 1'b0, 2'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_OTHER_SPEED, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                reply_of(1'b0, KIND_OTHER, 1'b1, 2'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h00}, 16'h0000, 16'hFFFF, 1'b0, '0);
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h03}, 16'h0409, 16'h00FF, 1'b0, '0);
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h04}, 16'h0409, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, 16'h0409, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_INTERFACE, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_GET_DESCRIPTOR, {DT_UNDEFINED, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                reply_of(1'b0, KIND_BYTE, 1'b0, 2'd0, 16'd1, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h00, RQ_SET_CONFIGURATION, 16'h0001, 16'h0000, 16'h0000, 1'b1,
                reply_of(1'b0, KIND_NONE, 1'b0, 2'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b0));
        add_row(8'h80, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0);
        add_row(8'h00, RQ_SET_CONFIGURATION, 16'h0002, 16'h0000, 16'h0000, 1'b1,
                STALL_REPLY);
        add_row(8'h00, RQ_SET_CONFIGURATION, 16'h0101, 16'h0000, 16'h0000, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_SET_CONFIGURATION, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, '0);
        add_row(8'h81, RQ_GET_INTERFACE, 16'h0000, 16'h0005, 16'h0000, 1'b1,
                reply_of(1'b0, KIND_BYTE, 1'b0, 2'd0, 16'd1, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(8'h01, RQ_SET_INTERFACE, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0);
        add_row(8'h01, RQ_SET_INTERFACE, 16'h0000, 16'h0001, 16'h0000, 1'b1, STALL_REPLY);
        add_row(8'h01, RQ_SET_INTERFACE, 16'h0100, 16'hFF00, 16'hFFFF, 1'b0, '0);
        add_row(8'hC0, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h81, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF, 1'b1,
                STALL_REPLY);
        add_row(8'h80, RQ_GET_INTERFACE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, STALL_REPLY);
        add_row(8'h80, RQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1, STALL_REPLY);
        add_row(8'hFF, RQ_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STALL_REPLY);

        snd_idle_pct = 19;
        rcv_stall_pct = 60;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_req(directed_rows[i].req, directed_rows[i].outcome);
        end

        for (int setting = 0; setting < SETTING_COUNT; setting++)
        begin
            if (setting == 2)
            begin
                snd_idle_pct = 60;
                rcv_stall_pct = 19;
            end
            else if (setting == 4)
            begin
                snd_idle_pct = 0;
                rcv_stall_pct = 0;
            end
            wait_for_replies();
            program_setting(setting);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                send_req(random_request(), '0);
            end
        end

        wait_for_replies();
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- usb_standard_request_decoder_unit.f -----
rtl/usrd_pkg.sv
rtl/usrd_cfg_regs.sv
rtl/usrd_decode.sv
rtl/usb_standard_request_decoder_unit.sv
tb/sv/usb_standard_request_decoder_unit_tb.sv
